### rtl/sae_pkg.sv
package sae_pkg;

   // fraction bits of the log2 and exp2 approximations
   localparam int ApproxStages = 24;
   localparam int FracBits = 40;

   // quotient bits of the two dividers
   localparam int RatioBits = 24;
   localparam int DensBits = 27;

   // field widths
   localparam int AltWidth = 25;
   localparam int TempWidth = 25;
   localparam int PresWidth = 35;
   localparam int DensWidth = 27;
   localparam int DenWidth = 49;
   localparam int CsrIndexWidth = 4;
   localparam int CsrDataWidth = 26;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] RegSeaLevelPressure = 4'd0;
   localparam logic [CsrIndexWidth-1:0] RegSeaLevelTemperature = 4'd1;
   localparam logic [CsrIndexWidth-1:0] RegLapseRate = 4'd2;
   localparam logic [CsrIndexWidth-1:0] RegGasConstant = 4'd3;
   localparam logic [CsrIndexWidth-1:0] RegMolarMass = 4'd4;
   localparam logic [CsrIndexWidth-1:0] RegGravity = 4'd5;
   localparam logic [CsrIndexWidth-1:0] RegWaterDensity = 4'd6;
   localparam logic [CsrIndexWidth-1:0] RegPressureExponent = 4'd7;

   // register reset values
   localparam logic [25:0] ResetPressure = 26'd25939200;
   localparam logic [24:0] ResetTemperature = 25'd18884198;
   localparam logic [20:0] ResetLapse = 21'd109051;
   localparam logic [23:0] ResetGas = 24'd544896;
   localparam logic [23:0] ResetMolar = 24'd485944;
   localparam logic [20:0] ResetGravity = 21'd642689;
   localparam logic [18:0] ResetWater = 19'd262042;
   localparam logic [19:0] ResetExponent = 20'd344443;

   // 10*log2(e) in q.24, 1.225 in q11.16, saturation limits
   localparam logic [27:0] KLog = 28'd242044063;
   localparam logic [DensWidth-1:0] AirDens = 27'd80282;
   localparam logic [PresWidth-1:0] PresMax = {PresWidth{1'b1}};
   localparam logic [DensWidth-1:0] DensMax = {DensWidth{1'b1}};
   localparam logic [31:0] OneQ31 = 32'h8000_0000;

   // fixed latency from request to result
   localparam int Latency = 3 + RatioBits + 1 + ApproxStages + 3 + ApproxStages + 4
                            + DensBits + 1;

   // one item as it travels down the chain
   typedef struct packed {
      logic                      valid;
      logic                      pos;
      logic                      flag;
      logic                      sat;
      logic [TempWidth-1:0]      temp;
      logic [PresWidth-1:0]      pres;
      logic [DensWidth-1:0]      dens;
      logic [DenWidth-1:0]       rem;
      logic [DenWidth-1:0]       den;
      logic [DensBits-1:0]       nbits;
      logic [DensBits-1:0]       quo;
      logic [30:0]               mant;
      logic [4:0]                lg_int;
      logic [ApproxStages-1:0]   frac;
      logic [44:0]               u;
      logic [44:0]               ph;
      logic [39:0]               pl;
      logic                      exp_big;
      logic [4:0]                exp_sh;
      logic [ApproxStages-1:0]   efrac;
      logic [31:0]               r;
      logic [31:0]               blend;
      logic [58:0]               mix;
      logic [49:0]               num;
   } sae_item_type;

   // integer square root, evaluated at elaboration only
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rest;
      logic [63:0] res;
      logic [63:0] bit_w;
      rest = v;
      res = 64'd0;
      bit_w = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rest >= res + bit_w) begin
            rest = rest - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // 2^(-2^-k) in q.31
   function automatic logic [31:0] exp_coef(input int k);
      logic [63:0] c;
      c = 64'd1 << 30;
      for (int j = 1; j <= FracBits; j++) begin
         if (j <= k) begin
            c = isqrt64(c << 31);
         end
      end
      return c[31:0];
   endfunction

endpackage

### rtl/sae_div_cell.sv
module sae_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sae_pkg::sae_item_type prev_item,
   output sae_pkg::sae_item_type next_item
);
   import sae_pkg::*;

   sae_item_type stage_ff;
   sae_item_type stage_in;
   logic [DenWidth:0] shifted;
   logic take;

   // one restoring step: bring in the next numerator bit, subtract if it fits
   always_comb begin
      stage_in = prev_item;
      shifted = {prev_item.rem, prev_item.nbits[DensBits-1]};
      take = shifted >= {1'b0, prev_item.den};
      if (take) begin
         stage_in.rem = DenWidth'(shifted - {1'b0, prev_item.den});
      end else begin
         stage_in.rem = shifted[DenWidth-1:0];
      end
      stage_in.quo = {prev_item.quo[DensBits-2:0], take};
      stage_in.nbits = {prev_item.nbits[DensBits-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end
   end

   assign next_item = stage_ff;

endmodule

### rtl/sae_log_cell.sv
module sae_log_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sae_pkg::sae_item_type prev_item,
   output sae_pkg::sae_item_type next_item
);
   import sae_pkg::*;

   sae_item_type stage_ff;
   sae_item_type stage_in;
   logic [61:0] sq;
   logic [31:0] sq_hi;

   // square the mantissa, one fraction bit of log2 falls out
   always_comb begin
      stage_in = prev_item;
      sq = prev_item.mant * prev_item.mant;
      sq_hi = sq[61:30];
      if (sq_hi[31]) begin
         stage_in.mant = sq_hi[31:1];
      end else begin
         stage_in.mant = sq_hi[30:0];
      end
      stage_in.frac = {prev_item.frac[ApproxStages-2:0], sq_hi[31]};
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end
   end

   assign next_item = stage_ff;

endmodule

### rtl/sae_exp_cell.sv
module sae_exp_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [31:0]           coef,
   input  sae_pkg::sae_item_type prev_item,
   output sae_pkg::sae_item_type next_item
);
   import sae_pkg::*;

   sae_item_type stage_ff;
   sae_item_type stage_in;
   logic [63:0] prod;

   // multiply in this cell's root of one half when its exponent bit is set
   always_comb begin
      stage_in = prev_item;
      prod = prev_item.r * coef;
      if (prev_item.efrac[ApproxStages-1]) begin
         stage_in.r = prod[62:31];
      end
      stage_in.efrac = {prev_item.efrac[ApproxStages-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end
   end

   assign next_item = stage_ff;

endmodule

### rtl/standard_atmosphere_evaluator_core.sv
// Troposphere evaluator: one altitude request per clock, one result per request.
// A request passes through a chain of cells: a 24-cell divider for the lapse
// ratio, 24 squaring cells for log2, 24 multiply cells for exp2 and a 27-cell
// divider for density, plus registered multiply stages around them. busy stays
// low, so every start is taken; rsp_valid pulses for one cycle with each result
// and the receiver has to take it then. Write the registers only when no request
// is in flight.
module standard_atmosphere_evaluator_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [sae_pkg::AltWidth-1:0]   req_altitude,
   output logic                                  rsp_valid,
   output logic [sae_pkg::TempWidth-1:0]         rsp_temperature,
   output logic [sae_pkg::PresWidth-1:0]         rsp_pressure,
   output logic [sae_pkg::DensWidth-1:0]         rsp_density,
   output logic                                  rsp_out_of_range,
   input  logic                                  csr_write_enable,
   input  logic [sae_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [sae_pkg::CsrDataWidth-1:0]      csr_write_data
);
   import sae_pkg::*;

   logic        req_accept;
   logic [AltWidth-1:0] alt_bits;

   logic [25:0] p0_ff;
   logic [24:0] t0_ff;
   logic [20:0] lapse_ff;
   logic [23:0] gas_ff;
   logic [23:0] molar_ff;
   logic [20:0] grav_ff;
   logic [18:0] water_ff;
   logic [19:0] xp_ff;
   logic [39:0] rgv_ff;
   logic [DensWidth-1:0] wden;
   logic        ge_ff;
   logic [DensWidth-1:0] diff_ff;

   logic        f1_valid_ff;
   logic        f1_pos_ff;
   logic [44:0] f1_lh_ff;
   logic [24:0] f1_d_ff;
   logic [28:0] drop;
   logic        flag_in;
   logic        f2_valid_ff;
   logic        f2_pos_ff;
   logic        f2_flag_ff;
   logic [24:0] f2_temp_ff;
   logic [24:0] f2_drop_ff;
   logic [15:0] f2_lhlo_ff;
   logic [52:0] f2_kt_ff;
   logic [40:0] f2_a1_ff;
   logic [48:0] f2_a2_ff;
   logic [41:0] pres_sum;
   logic [FracBits-1:0] tfrac;

   sae_item_type load_ff, load_in;
   sae_item_type lp_ff, lp_in;
   sae_item_type e1_ff, e1_in;
   sae_item_type e2_ff, e2_in;
   sae_item_type e3_ff, e3_in;
   sae_item_type x1_ff, x1_in;
   sae_item_type x2_ff, x2_in;
   sae_item_type x3_ff, x3_in;
   sae_item_type x4_ff, x4_in;
   sae_item_type ratio_chain [0:RatioBits];
   sae_item_type log_chain [0:ApproxStages];
   sae_item_type exp_chain [0:ApproxStages];
   sae_item_type dens_chain [0:DensBits];

   logic [24:0] base;
   logic [4:0]  lead;
   logic [49:0] e_val;
   logic [31:0] r_sh;
   logic [57:0] pres_prod;
   logic [27:0] mix_hi;
   logic [27:0] dens_sum;

   logic                 rsp_valid_ff;
   logic [TempWidth-1:0] rsp_temp_ff;
   logic [PresWidth-1:0] rsp_pres_ff;
   logic [DensWidth-1:0] rsp_dens_ff;
   logic                 rsp_oor_ff;
   sae_item_type         tail;

   assign busy = 1'b0;
   assign req_accept = start && !busy;
   assign alt_bits = req_altitude;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         p0_ff <= ResetPressure;
         t0_ff <= ResetTemperature;
         lapse_ff <= ResetLapse;
         gas_ff <= ResetGas;
         molar_ff <= ResetMolar;
         grav_ff <= ResetGravity;
         water_ff <= ResetWater;
         xp_ff <= ResetExponent;
      end else if (csr_write_enable) begin
         case (csr_index)
            RegSeaLevelPressure: p0_ff <= csr_write_data[25:0];
            RegSeaLevelTemperature: t0_ff <= csr_write_data[24:0];
            RegLapseRate: lapse_ff <= csr_write_data[20:0];
            RegGasConstant: gas_ff <= csr_write_data[23:0];
            RegMolarMass: molar_ff <= csr_write_data[23:0];
            RegGravity: grav_ff <= csr_write_data[20:0];
            RegWaterDensity: water_ff <= csr_write_data[18:0];
            RegPressureExponent: xp_ff <= csr_write_data[19:0];
            default: ;
         endcase
      end
   end

   // terms that depend on configuration only
   assign wden = {water_ff, 8'd0};
   always_ff @(posedge clock) begin
      rgv_ff <= water_ff * grav_ff;
      ge_ff <= wden >= AirDens;
      if (wden >= AirDens) begin
         diff_ff <= wden - AirDens;
      end else begin
         diff_ff <= AirDens - wden;
      end
   end

   // front stage 1: branch select, lapse product, depth
   always_ff @(posedge clock) begin
      f1_pos_ff <= (alt_bits != '0) && !alt_bits[AltWidth-1];
      f1_lh_ff <= lapse_ff * alt_bits[23:0];
      f1_d_ff <= 25'(25'd0 - alt_bits);
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= req_accept;
      end
   end

   // front stage 2: range check, temperature, depth products
   assign drop = f1_lh_ff[44:16];
   assign flag_in = f1_pos_ff && (drop >= {4'd0, t0_ff});
   always_ff @(posedge clock) begin
      f2_pos_ff <= f1_pos_ff;
      f2_flag_ff <= flag_in;
      if (!f1_pos_ff) begin
         f2_temp_ff <= t0_ff;
      end else if (flag_in) begin
         f2_temp_ff <= '0;
      end else begin
         f2_temp_ff <= t0_ff - drop[24:0];
      end
      f2_drop_ff <= drop[24:0];
      f2_lhlo_ff <= f1_lh_ff[15:0];
      f2_kt_ff <= f1_d_ff * KLog;
      f2_a1_ff <= rgv_ff[39:24] * f1_d_ff;
      f2_a2_ff <= rgv_ff[23:0] * f1_d_ff;
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   // front stage 3: depth pressure, exp argument below zero, divider load
   assign pres_sum = 42'(p0_ff) + 42'(f2_a1_ff) + 42'(f2_a2_ff[48:24]);
   assign tfrac = {f2_kt_ff[31:0], 8'd0};
   always_comb begin
      load_in = '0;
      load_in.valid = f2_valid_ff;
      load_in.pos = f2_pos_ff;
      load_in.flag = f2_flag_ff;
      load_in.temp = f2_temp_ff;
      if (pres_sum > 42'(PresMax)) begin
         load_in.pres = PresMax;
      end else begin
         load_in.pres = pres_sum[PresWidth-1:0];
      end
      load_in.rem = DenWidth'(f2_drop_ff);
      load_in.den = DenWidth'(t0_ff);
      load_in.nbits = {f2_lhlo_ff, 11'd0};
      load_in.exp_big = |f2_kt_ff[52:37];
      load_in.exp_sh = f2_kt_ff[36:32];
      load_in.efrac = tfrac[FracBits-1 -: ApproxStages];
      load_in.r = OneQ31;
   end

   always_ff @(posedge clock) begin
      load_ff <= load_in;
      if (reset) begin
         load_ff.valid <= 1'b0;
      end
   end

   // ratio divider
   assign ratio_chain[0] = load_ff;
   for (genvar gi = 0; gi < RatioBits; gi++) begin : g_ratio
      sae_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_item (ratio_chain[gi]),
         .next_item (ratio_chain[gi+1])
      );
   end

   // log prep: base and normalized mantissa
   always_comb begin
      lp_in = ratio_chain[RatioBits];
      base = 25'(25'h100_0000 - {1'b0, ratio_chain[RatioBits].quo[RatioBits-1:0]});
      lead = '0;
      for (int i = 0; i < 25; i++) begin
         if (base[i]) begin
            lead = 5'(i);
         end
      end
      lp_in.mant = 31'(31'(base) << (5'd30 - lead));
      lp_in.lg_int = 5'(5'd24 - lead);
   end

   always_ff @(posedge clock) begin
      lp_ff <= lp_in;
      if (reset) begin
         lp_ff.valid <= 1'b0;
      end
   end

   // log2 squaring cells
   assign log_chain[0] = lp_ff;
   for (genvar gi = 0; gi < ApproxStages; gi++) begin : g_log
      sae_log_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_item (log_chain[gi]),
         .next_item (log_chain[gi+1])
      );
   end

   // -log2 of base
   always_comb begin
      e1_in = log_chain[ApproxStages];
      e1_in.u = {log_chain[ApproxStages].lg_int, 40'd0}
                - (45'(log_chain[ApproxStages].frac) << (FracBits - ApproxStages));
   end

   // exponent products
   always_comb begin
      e2_in = e1_ff;
      e2_in.ph = xp_ff * e1_ff.u[44:20];
      e2_in.pl = xp_ff * e1_ff.u[19:0];
   end

   // exp argument above zero
   always_comb begin
      e3_in = e2_ff;
      e_val = 50'({e2_ff.ph, 4'd0}) + 50'(e2_ff.pl >> 16);
      if (e2_ff.pos) begin
         e3_in.exp_big = |e_val[49:45];
         e3_in.exp_sh = e_val[44:40];
         e3_in.efrac = e_val[FracBits-1 -: ApproxStages];
      end
   end

   always_ff @(posedge clock) begin
      e1_ff <= e1_in;
      e2_ff <= e2_in;
      e3_ff <= e3_in;
      if (reset) begin
         e1_ff.valid <= 1'b0;
         e2_ff.valid <= 1'b0;
         e3_ff.valid <= 1'b0;
      end
   end

   // exp2 multiply cells
   assign exp_chain[0] = e3_ff;
   for (genvar gi = 0; gi < ApproxStages; gi++) begin : g_exp
      localparam logic [31:0] Coef = exp_coef(gi + 1);
      sae_exp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .coef      (Coef),
         .prev_item (exp_chain[gi]),
         .next_item (exp_chain[gi+1])
      );
   end

   // integer part of the exponent and blend weight
   always_comb begin
      x1_in = exp_chain[ApproxStages];
      if (exp_chain[ApproxStages].exp_big) begin
         r_sh = '0;
      end else begin
         r_sh = exp_chain[ApproxStages].r >> exp_chain[ApproxStages].exp_sh;
      end
      x1_in.r = r_sh;
      x1_in.blend = OneQ31 - r_sh;
   end

   // pressure above zero, density blend product below
   always_comb begin
      x2_in = x1_ff;
      pres_prod = p0_ff * x1_ff.r;
      if (x1_ff.pos) begin
         x2_in.pres = 35'(pres_prod[57:31]);
      end
      x2_in.mix = diff_ff * x1_ff.blend;
   end

   // density operands above zero, blended density below
   always_comb begin
      x3_in = x2_ff;
      mix_hi = x2_ff.mix[58:31];
      if (ge_ff) begin
         dens_sum = 28'(AirDens) + mix_hi;
      end else begin
         dens_sum = 28'(AirDens) - mix_hi;
      end
      if (x2_ff.pos) begin
         x3_in.num = molar_ff * x2_ff.pres[25:0];
         x3_in.den = gas_ff * x2_ff.temp;
      end else begin
         x3_in.dens = dens_sum[DensWidth-1:0];
      end
   end

   // saturation check and density divider load
   always_comb begin
      x4_in = x3_ff;
      x4_in.sat = {10'd0, x3_ff.num} >= {x3_ff.den, 11'd0};
      x4_in.rem = DenWidth'(x3_ff.num >> 11);
      x4_in.nbits = {x3_ff.num[10:0], 16'd0};
      x4_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      x1_ff <= x1_in;
      x2_ff <= x2_in;
      x3_ff <= x3_in;
      x4_ff <= x4_in;
      if (reset) begin
         x1_ff.valid <= 1'b0;
         x2_ff.valid <= 1'b0;
         x3_ff.valid <= 1'b0;
         x4_ff.valid <= 1'b0;
      end
   end

   // density divider
   assign dens_chain[0] = x4_ff;
   for (genvar gi = 0; gi < DensBits; gi++) begin : g_dens
      sae_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_item (dens_chain[gi]),
         .next_item (dens_chain[gi+1])
      );
   end

   // result register
   assign tail = dens_chain[DensBits];
   always_ff @(posedge clock) begin
      rsp_oor_ff <= tail.flag;
      rsp_temp_ff <= tail.flag ? '0 : tail.temp;
      rsp_pres_ff <= tail.flag ? '0 : tail.pres;
      if (!tail.pos) begin
         rsp_dens_ff <= tail.dens;
      end else if (tail.flag) begin
         rsp_dens_ff <= '0;
      end else if (tail.sat) begin
         rsp_dens_ff <= DensMax;
      end else begin
         rsp_dens_ff <= tail.quo;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= tail.valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_temperature = rsp_temp_ff;
   assign rsp_pressure = rsp_pres_ff;
   assign rsp_density = rsp_dens_ff;
   assign rsp_out_of_range = rsp_oor_ff;

`ifndef ASSERT_OFF
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##Latency rsp_valid)
      else $error("request did not produce a result at the fixed latency");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept, Latency))
      else $error("result without a matching request");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |->
         rsp_temperature == '0 && rsp_pressure == '0 && rsp_density == '0)
      else $error("out of range result not saturated to zero");

   a_mant_norm: assert property (@(posedge clock) disable iff (reset)
      lp_ff.valid && lp_ff.pos && !lp_ff.flag |-> lp_ff.mant[30])
      else $error("log mantissa not normalized");
`endif

endmodule

### test/standard_atmosphere_evaluator_core_tb.sv
module standard_atmosphere_evaluator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sae_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int NumRegs = 8;

   typedef struct {
      logic [TempWidth-1:0] temp;
      logic [PresWidth-1:0] pres;
      logic [DensWidth-1:0] dens;
      logic                 oor;
   } atmo_result_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic signed [AltWidth-1:0]   req_altitude;
   logic                         rsp_valid;
   logic [TempWidth-1:0]         rsp_temperature;
   logic [PresWidth-1:0]         rsp_pressure;
   logic [DensWidth-1:0]         rsp_density;
   logic                         rsp_out_of_range;
   logic                         csr_write_enable;
   logic [CsrIndexWidth-1:0]     csr_index;
   logic [CsrDataWidth-1:0]      csr_write_data;

   logic signed [AltWidth-1:0]   pending_altitudes[$];
   atmo_result_type              expected_results[$];
   longint unsigned              atmo_reg[NumRegs];
   int                           idle_pct;
   int                           error_count;
   int                           cycle_count;

   standard_atmosphere_evaluator_core u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_altitude     (req_altitude),
      .rsp_valid        (rsp_valid),
      .rsp_temperature  (rsp_temperature),
      .rsp_pressure     (rsp_pressure),
      .rsp_density      (rsp_density),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // integer square root, bit by bit
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned rest;
      longint unsigned root;
      longint unsigned probe;
      rest = v;
      root = 0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > rest) probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // -log2(b / 2^24) in q.40, b in 1..2^24
   function automatic longint unsigned minus_log2(input longint unsigned b);
      int              lead;
      longint unsigned mant;
      longint unsigned frac;
      lead = 0;
      frac = 0;
      while (lead < 24 && (b >> (lead + 1)) != 0) lead++;
      mant = b << (30 - lead);
      for (int i = 1; i <= ApproxStages; i++) begin
         mant = (mant * mant) >> 30;
         if (mant >= 64'h8000_0000) begin
            mant = mant >> 1;
            frac = frac | (64'd1 << (FracBits - i));
         end
      end
      return (longint'(24 - lead) << FracBits) - frac;
   endfunction

   // 2^(-e) in q.31, e in q.40
   function automatic longint unsigned pow2_neg(input longint unsigned e);
      longint unsigned whole;
      longint unsigned prod;
      longint unsigned coef;
      whole = e >> FracBits;
      prod = 64'h8000_0000;
      coef = 64'd1 << 30;
      for (int k = 1; k <= ApproxStages; k++) begin
         coef = int_sqrt(coef << 31);
         if ((e >> (FracBits - k)) & 64'd1) prod = (prod * coef) >> 31;
      end
      if (whole >= 32) return 0;
      return prod >> whole;
   endfunction

   // floor(num * 2^16 / den) with saturation
   function automatic longint unsigned density_quotient(input longint unsigned num,
                                                        input longint unsigned den);
      longint unsigned q;
      longint unsigned rem;
      if (den == 0) return DensMax;
      q = num / den;
      rem = num % den;
      if (q >= 2048) return DensMax;
      for (int i = 0; i < 16; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q = q | 64'd1;
         end
      end
      return (q > DensMax) ? DensMax : q;
   endfunction

   // expected atmosphere for one altitude under the current registers
   function automatic atmo_result_type atmosphere_at(input logic [AltWidth-1:0] alt);
      atmo_result_type res;
      longint unsigned raw, p0, t0, lr, rg, mm, gr, rw, xp;
      longint unsigned lh, drop, ratio, u, e, temp, pres, dens;
      longint unsigned depth, rgv, add, r, w, blend;
      logic            flag;
      raw = alt;
      p0 = atmo_reg[RegSeaLevelPressure];
      t0 = atmo_reg[RegSeaLevelTemperature];
      lr = atmo_reg[RegLapseRate];
      rg = atmo_reg[RegGasConstant];
      mm = atmo_reg[RegMolarMass];
      gr = atmo_reg[RegGravity];
      rw = atmo_reg[RegWaterDensity];
      xp = atmo_reg[RegPressureExponent];
      flag = 1'b0;
      if (raw != 0 && alt[AltWidth-1] == 1'b0) begin
         // above the surface: lapse, barometric power, ideal gas
         lh = lr * raw;
         drop = lh >> 16;
         ratio = 0;
         if (t0 == 0 || drop >= t0) begin
            flag = 1'b1;
         end else begin
            ratio = (lh << 8) / t0;
            if (ratio >= (64'd1 << 24)) flag = 1'b1;
         end
         if (flag) begin
            temp = 0;
            pres = 0;
            dens = 0;
         end else begin
            u = minus_log2((64'd1 << 24) - ratio);
            e = ((xp * (u >> 20)) << 4) + ((xp * (u & 64'hF_FFFF)) >> 16);
            temp = t0 - drop;
            pres = (p0 * pow2_neg(e)) >> 31;
            dens = density_quotient(mm * pres, rg * temp);
         end
      end else begin
         // at or below the surface: hydrostatic pressure, density blend
         depth = (raw == 0) ? 0 : ((64'd1 << 25) - raw);
         rgv = rw * gr;
         add = (rgv >> 24) * depth + (((rgv & 64'hFF_FFFF) * depth) >> 24);
         r = pow2_neg((depth * KLog) << 8);
         w = rw << 8;
         blend = 64'h8000_0000 - r;
         temp = t0;
         pres = p0 + add;
         if (pres > PresMax) pres = PresMax;
         if (w >= AirDens) dens = AirDens + (((w - AirDens) * blend) >> 31);
         else dens = AirDens - (((AirDens - w) * blend) >> 31);
      end
      res.temp = temp[TempWidth-1:0];
      res.pres = pres[PresWidth-1:0];
      res.dens = dens[DensWidth-1:0];
      res.oor = flag;
      return res;
   endfunction

   // register mirror follows the write port
   always @(posedge clock) begin
      if (reset) begin
         atmo_reg[RegSeaLevelPressure] <= ResetPressure;
         atmo_reg[RegSeaLevelTemperature] <= ResetTemperature;
         atmo_reg[RegLapseRate] <= ResetLapse;
         atmo_reg[RegGasConstant] <= ResetGas;
         atmo_reg[RegMolarMass] <= ResetMolar;
         atmo_reg[RegGravity] <= ResetGravity;
         atmo_reg[RegWaterDensity] <= ResetWater;
         atmo_reg[RegPressureExponent] <= ResetExponent;
      end else if (csr_write_enable) begin
         case (csr_index)
            RegSeaLevelPressure:
               atmo_reg[RegSeaLevelPressure] <= csr_write_data[25:0];
            RegSeaLevelTemperature:
               atmo_reg[RegSeaLevelTemperature] <= csr_write_data[24:0];
            RegLapseRate:
               atmo_reg[RegLapseRate] <= csr_write_data[20:0];
            RegGasConstant:
               atmo_reg[RegGasConstant] <= csr_write_data[23:0];
            RegMolarMass:
               atmo_reg[RegMolarMass] <= csr_write_data[23:0];
            RegGravity:
               atmo_reg[RegGravity] <= csr_write_data[20:0];
            RegWaterDensity:
               atmo_reg[RegWaterDensity] <= csr_write_data[18:0];
            RegPressureExponent:
               atmo_reg[RegPressureExponent] <= csr_write_data[19:0];
            default: ;
         endcase
      end
   end

   // request driver
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) expected_results.push_back(atmosphere_at(req_altitude));
         if (start && busy) begin
            start <= 1'b1;
         end else if (pending_altitudes.size() > 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_altitude <= pending_altitudes.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      error_count++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   // result monitor
   always @(posedge clock) begin
      atmo_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_temperature !== exp_res.temp)
               report_mismatch("temperature", rsp_temperature, exp_res.temp);
            if (rsp_pressure !== exp_res.pres)
               report_mismatch("pressure", rsp_pressure, exp_res.pres);
            if (rsp_density !== exp_res.dens)
               report_mismatch("density", rsp_density, exp_res.dens);
            if (rsp_out_of_range !== exp_res.oor)
               report_mismatch("out_of_range", rsp_out_of_range, exp_res.oor);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("** standard_atmosphere_evaluator_core: FAILED **");
         $finish;
      end
   end

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx, input longint unsigned val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val[CsrDataWidth-1:0];
   endtask

   task automatic load_atmosphere(input longint unsigned p0, input longint unsigned t0,
                                  input longint unsigned lr, input longint unsigned rg,
                                  input longint unsigned mm, input longint unsigned gr,
                                  input longint unsigned rw, input longint unsigned xp);
      write_reg(RegSeaLevelPressure, p0);
      write_reg(RegSeaLevelTemperature, t0);
      write_reg(RegLapseRate, lr);
      write_reg(RegGasConstant, rg);
      write_reg(RegMolarMass, mm);
      write_reg(RegGravity, gr);
      write_reg(RegWaterDensity, rw);
      write_reg(RegPressureExponent, xp);
      // an index past the last register must change nothing
      write_reg(4'(NumRegs + $urandom_range(7)), $urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // wait for every request to drain, then let the chain empty
   task automatic drain();
      do @(posedge clock);
      while (pending_altitudes.size() != 0 || start || expected_results.size() != 0);
      repeat (Latency + 8) @(posedge clock);
   endtask

   function automatic longint unsigned near_value(input longint unsigned def,
                                                  input longint unsigned lo,
                                                  input longint unsigned hi);
      longint unsigned v;
      if ($urandom_range(3) == 0) v = lo + longint'($urandom) % (hi - lo + 1);
      else v = def / 2 + longint'($urandom) % (def + 1);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
   endfunction

   function automatic logic signed [AltWidth-1:0] random_altitude();
      int sel;
      sel = $urandom_range(99);
      if (sel < 55) return AltWidth'($urandom_range(11520000, 0));
      if (sel < 80) return AltWidth'(-$signed($urandom_range(2816000, 0)));
      if (sel < 95) return AltWidth'($signed($urandom_range(2000, 0)) - 1000);
      return (sel < 98) ? 25'sd11520000 : -25'sd2816000;
   endfunction

   initial begin
      start = 1'b0;
      req_altitude = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      idle_pct = 0;
      error_count = 0;
      cycle_count = 0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset registers: surface, depth extremes, flag edge near the top
      pending_altitudes = '{25'sd0, 25'sd1, -25'sd1, 25'sd11520000, -25'sd2816000,
                            25'sd2560000, 25'sd11300000, 25'sd11400000};
      drain();

      // every register at its top, depth pressure saturates
      load_atmosphere(67108863, 26214400, 1048576, 16777215, 16777215, 2097151, 524287,
                      1048575);
      pending_altitudes = '{25'sd1, -25'sd2816000, -25'sd1, 25'sd11520000, 25'sd256};
      drain();

      // every register at its bottom: zero temperature flags above only
      load_atmosphere(0, 0, 0, 1, 0, 0, 0, 0);
      pending_altitudes = '{25'sd1, 25'sd0, -25'sd2816000, 25'sd11520000};
      drain();

      // tiny gas constant saturates density, water lighter than air
      load_atmosphere(ResetPressure, ResetTemperature, ResetLapse, 1, 16777215, ResetGravity,
                      100, ResetExponent);
      pending_altitudes = '{25'sd2560, 25'sd1000000, -25'sd256, -25'sd2816000, 25'sd0};
      drain();

      // random registers and altitudes, idling changes every two settings
      for (int phase = 0; phase < 6; phase++) begin
         idle_pct = (phase < 2) ? 34 : (phase < 4) ? 74 : 0;
         load_atmosphere(near_value(ResetPressure, 0, 67108863),
                         near_value(ResetTemperature, 0, 26214400),
                         near_value(ResetLapse, 0, 1048576),
                         near_value(ResetGas, 1, 16777215),
                         near_value(ResetMolar, 0, 16777215),
                         near_value(ResetGravity, 0, 2097151),
                         near_value(ResetWater, 0, 524287),
                         near_value(ResetExponent, 0, 1048575));
         for (int i = 0; i < 232; i++) pending_altitudes.push_back(random_altitude());
         drain();
      end

      if (error_count == 0) begin
         $display("** standard_atmosphere_evaluator_core: PASSED **");
      end else begin
         $display("** standard_atmosphere_evaluator_core: FAILED **");
      end
      $finish;
   end

endmodule
